>>> hdl/settable_clock_with_segment_display_defines.svh
// Assertion macros of the settable clock RTL, used by scd_core.
`ifndef SETTABLE_CLOCK_WITH_SEGMENT_DISPLAY_DEFINES_SVH
`define SETTABLE_CLOCK_WITH_SEGMENT_DISPLAY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scd check failed");

// Next-cycle implication, checked out of reset.
`define SCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scd check failed");

`endif

>>> hdl/scd_pkg.sv
// Package with types, constants and digit helpers of the settable clock.
package scd_pkg;

  localparam int unsigned CFG_WIDTH = 16;

  localparam logic CFG_SECOND_LIMIT = 1'b0;
  localparam logic CFG_BLINK_SPLIT  = 1'b1;

  localparam logic [CFG_WIDTH-1:0] SECOND_LIMIT_RESET = 16'd5000;
  localparam logic [CFG_WIDTH-1:0] BLINK_SPLIT_RESET  = 16'd2500;

  localparam logic [3:0] KEY_NONE = 4'hF;
  localparam logic [3:0] KEY_INC  = 4'hE;
  localparam logic [3:0] KEY_DEC  = 4'hD;
  localparam logic [3:0] KEY_SEL  = 4'hB;
  localparam logic [3:0] KEY_MODE = 4'h7;

  localparam logic [5:0] SECOND_WRAP = 6'd60;
  localparam logic [5:0] MINUTE_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX    = 5'd23;

  localparam logic [7:0] POINT_BIT = 8'h10;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  localparam logic [7:0] SEG_CODE [10] = '{
    8'hE7, 8'h21, 8'hCB, 8'h6B, 8'h2D, 8'h6E, 8'hEE, 8'h23, 8'hEF, 8'h6F
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic       show;
    logic       editing;
    logic       minute_selected;
  } disp_t;

  typedef struct packed {
    logic [7:0] seg_hour_tens;
    logic [7:0] seg_hour_ones;
    logic [7:0] seg_minute_tens;
    logic [7:0] seg_minute_ones;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic       editing;
    logic       minute_selected;
  } result_t;

  function automatic logic [3:0] tens_of(input logic [5:0] v);
    if (v >= 6'd50) begin
      return 4'd5;
    end else if (v >= 6'd40) begin
      return 4'd4;
    end else if (v >= 6'd30) begin
      return 4'd3;
    end else if (v >= 6'd20) begin
      return 4'd2;
    end else if (v >= 6'd10) begin
      return 4'd1;
    end
    return 4'd0;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(6'(tens_of(v)) * 6'd10);
    return r[3:0];
  endfunction

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    return (d < 4'd10) ? SEG_CODE[d] : SEG_CODE[0];
  endfunction

endpackage

>>> hdl/scd_in_if.sv
// Channel carrying one tick flag and one switch sample per request.
interface scd_in_if;
  logic       valid;
  logic       ready;
  logic       tick;
  logic [3:0] switches;

  modport source (output valid, tick, switches, input ready);
  modport sink (input valid, tick, switches, output ready);
endinterface

>>> hdl/scd_out_if.sv
// Channel carrying the segment bytes and time fields of one result.
interface scd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] seg_hour_tens;
  logic [7:0] seg_hour_ones;
  logic [7:0] seg_minute_tens;
  logic [7:0] seg_minute_ones;
  logic [4:0] hour_value;
  logic [5:0] minute_value;
  logic       editing;
  logic       minute_selected;

  modport source (output valid, seg_hour_tens, seg_hour_ones, seg_minute_tens,
                  seg_minute_ones, hour_value, minute_value, editing, minute_selected,
                  input ready);
  modport sink (input valid, seg_hour_tens, seg_hour_ones, seg_minute_tens,
                seg_minute_ones, hour_value, minute_value, editing, minute_selected,
                output ready);
endinterface

>>> hdl/scd_core.sv
// Time keeping, key edge detection and mode control of the settable clock.
`include "settable_clock_with_segment_display_defines.svh"

module scd_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           tick,
  input  logic [3:0]                     switches,
  input  logic [scd_pkg::CFG_WIDTH-1:0]  second_limit,
  input  logic [scd_pkg::CFG_WIDTH-1:0]  blink_split,
  output scd_pkg::disp_t                 disp
);
  import scd_pkg::*;

  logic [CFG_WIDTH-1:0] tick_count, tick_count_next;
  logic [5:0]           second_count, second_count_next;
  logic [5:0]           minute_count, minute_count_next;
  logic [4:0]           hour_count, hour_count_next;
  logic                 edit_flag, edit_flag_next;
  logic                 field_flag, field_flag_next;
  logic                 key_armed, key_armed_next;
  logic [3:0]           key;

  always_comb begin
    tick_count_next   = tick_count;
    second_count_next = second_count;
    minute_count_next = minute_count;
    hour_count_next   = hour_count;
    edit_flag_next    = edit_flag;
    field_flag_next   = field_flag;
    key_armed_next    = key_armed;
    key               = KEY_NONE;

    if (tick) begin
      if (tick_count == second_limit) begin
        tick_count_next = '0;
        if (!edit_flag) begin
          second_count_next = second_count + 6'd1;
        end
      end else begin
        tick_count_next = tick_count + 16'd1;
      end
    end

    if (switches != KEY_NONE && key_armed) begin
      key_armed_next = 1'b0;
      key            = switches;
    end else if (switches == KEY_NONE) begin
      key_armed_next = 1'b1;
    end

    if (key == KEY_MODE) begin
      if (edit_flag) begin
        second_count_next = '0;
      end
      edit_flag_next = !edit_flag;
    end

    disp.show = tick_count_next < blink_split;

    if (!edit_flag_next) begin
      disp.hour   = hour_count;
      disp.minute = minute_count;
      if (second_count_next >= SECOND_WRAP) begin
        second_count_next = '0;
        if (minute_count >= MINUTE_MAX) begin
          minute_count_next = '0;
          hour_count_next   = (hour_count >= HOUR_MAX) ? 5'd0 : hour_count + 5'd1;
        end else begin
          minute_count_next = minute_count + 6'd1;
        end
      end
    end else begin
      if (key == KEY_SEL) begin
        field_flag_next = !field_flag;
      end
      if (key == KEY_INC) begin
        if (field_flag_next) begin
          minute_count_next = (minute_count >= MINUTE_MAX) ? 6'd0 : minute_count + 6'd1;
        end else begin
          hour_count_next = (hour_count >= HOUR_MAX) ? 5'd0 : hour_count + 5'd1;
        end
      end
      if (key == KEY_DEC) begin
        if (field_flag_next) begin
          minute_count_next = (minute_count == 6'd0 || minute_count > MINUTE_MAX) ?
                              MINUTE_MAX : minute_count - 6'd1;
        end else begin
          hour_count_next = (hour_count == 5'd0 || hour_count > HOUR_MAX) ?
                            HOUR_MAX : hour_count - 5'd1;
        end
      end
      disp.hour   = hour_count_next;
      disp.minute = minute_count_next;
    end

    disp.editing         = edit_flag_next;
    disp.minute_selected = field_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      second_count <= '0;
      minute_count <= '0;
      hour_count   <= '0;
      edit_flag    <= 1'b0;
      field_flag   <= 1'b1;
      key_armed    <= 1'b1;
    end else if (advance) begin
      tick_count   <= tick_count_next;
      second_count <= second_count_next;
      minute_count <= minute_count_next;
      hour_count   <= hour_count_next;
      edit_flag    <= edit_flag_next;
      field_flag   <= field_flag_next;
      key_armed    <= key_armed_next;
    end
  end

  `SCD_ASSERT_NEXT(a_edit_holds_seconds, edit_flag,
                   second_count == $past(second_count) || second_count == 6'd0)
  `SCD_ASSERT_NEXT(a_run_minute_steps, !edit_flag,
                   minute_count == $past(minute_count) ||
                   minute_count == $past(minute_count) + 6'd1 || minute_count == 6'd0)
  `SCD_ASSERT_NEXT(a_mode_key_enters_edit,
                   advance && !edit_flag && key == KEY_MODE, edit_flag)
  `SCD_ASSERT_NOW(a_time_in_range, !rst, hour_count <= HOUR_MAX && minute_count <= MINUTE_MAX)

endmodule

>>> hdl/scd_seg.sv
// Seven-segment encoding, blinking point and field blanking of one result.
module scd_seg (
  input  scd_pkg::disp_t   disp,
  output scd_pkg::result_t result
);
  import scd_pkg::*;

  logic [5:0] hour_wide;
  logic       blank;

  assign hour_wide = {1'b0, disp.hour};
  assign blank     = disp.editing && !disp.show;

  always_comb begin
    result.seg_hour_tens   = seg_of(tens_of(hour_wide));
    result.seg_hour_ones   = seg_of(ones_of(hour_wide));
    result.seg_minute_tens = seg_of(tens_of(disp.minute));
    result.seg_minute_ones = seg_of(ones_of(disp.minute));
    if (!disp.editing && disp.show) begin
      result.seg_hour_ones = result.seg_hour_ones | POINT_BIT;
    end
    if (blank) begin
      if (disp.minute_selected) begin
        result.seg_minute_tens = SEG_BLANK;
        result.seg_minute_ones = SEG_BLANK;
      end else begin
        result.seg_hour_tens = SEG_BLANK;
        result.seg_hour_ones = SEG_BLANK;
      end
    end
    result.hour_value      = disp.hour;
    result.minute_value    = disp.minute;
    result.editing         = disp.editing;
    result.minute_selected = disp.minute_selected;
  end

endmodule

>>> hdl/settable_clock_with_segment_display.sv
// Top level of the 24-hour settable clock with four-digit segment output.
//
//   channel   dir   handshake        payload
//   samples   in    valid / ready    tick, switches
//   display   out   valid / ready    four segment bytes, hour, minute, mode, field
//   cfg       in    cfg_write        cfg_index, cfg_data
//
// A request is taken into an input register and its result is registered in
// the output register as it advances; one request is taken every cycle
// while the display channel does not stall.
// While a result stalls, a request is still taken into the input stage only if that stage is empty.
// Synchronous reset clears the time, the mode and both stage valid flags.
module settable_clock_with_segment_display (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [scd_pkg::CFG_WIDTH-1:0] cfg_data,
  scd_in_if.sink                        samples,
  scd_out_if.source                     display
);
  import scd_pkg::*;

  logic                 in_valid;
  logic                 in_tick;
  logic [3:0]           in_switches;
  logic                 out_valid;
  result_t              out_result;
  logic                 advance;
  logic [CFG_WIDTH-1:0] second_limit;
  logic [CFG_WIDTH-1:0] blink_split;
  disp_t                disp;
  result_t              result;

  assign advance       = in_valid && (!out_valid || display.ready);
  assign samples.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_limit <= SECOND_LIMIT_RESET;
      blink_split  <= BLINK_SPLIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_SECOND_LIMIT) begin
        second_limit <= cfg_data;
      end else begin
        blink_split <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_tick     <= samples.tick;
      in_switches <= samples.switches;
    end
  end

  scd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .tick         (in_tick),
    .switches     (in_switches),
    .second_limit (second_limit),
    .blink_split  (blink_split),
    .disp         (disp)
  );

  scd_seg u_seg (
    .disp   (disp),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (display.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign display.valid           = out_valid;
  assign display.seg_hour_tens   = out_result.seg_hour_tens;
  assign display.seg_hour_ones   = out_result.seg_hour_ones;
  assign display.seg_minute_tens = out_result.seg_minute_tens;
  assign display.seg_minute_ones = out_result.seg_minute_ones;
  assign display.hour_value      = out_result.hour_value;
  assign display.minute_value    = out_result.minute_value;
  assign display.editing         = out_result.editing;
  assign display.minute_selected = out_result.minute_selected;

endmodule

>>> dv/settable_clock_with_segment_display_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the settable 24-hour clock with segment display.
module settable_clock_with_segment_display_tb;
  import scd_pkg::*;

  localparam logic [3:0] KEY_STRAY = 4'h3;
  localparam int IDLE_LIMIT = 2000;
  localparam int REPORT_LIMIT = 40;

  typedef struct {
    logic       tick;
    logic [3:0] switches;
    bit         typed;
    result_t    want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic                 cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  scd_in_if  samples_ch ();
  scd_out_if display_ch ();

  settable_clock_with_segment_display u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (samples_ch),
    .display  (display_ch)
  );

  logic [15:0] second_limit;
  logic [15:0] blink_split;
  logic [15:0] tick_count;
  logic [5:0]  second_count;
  logic [5:0]  minute_count;
  logic [4:0]  hour_count;
  logic        edit_mode;
  logic        minute_field;
  logic        key_armed;

  result_t       pending_displays[$];
  directed_row_t directed_rows[28];

  int          requests_sent;
  int          results_checked;
  int          errors;
  int          mode_changes;
  int          hour_wraps;
  int          idle_cycles;
  int          burst_left;
  bit          pacing;
  bit          allow_idle;
  logic [15:0] stall_pattern;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t advance_clock(input logic tick, input logic [3:0] sw);
    result_t    r;
    logic [3:0] key;
    logic       show;
    key = KEY_NONE;
    if (tick) begin
      if (tick_count == second_limit) begin
        tick_count = '0;
        if (!edit_mode) begin
          second_count = second_count + 6'd1;
        end
      end else begin
        tick_count = tick_count + 16'd1;
      end
    end
    if (sw != KEY_NONE && key_armed) begin
      key_armed = 1'b0;
      key = sw;
    end else if (sw == KEY_NONE) begin
      key_armed = 1'b1;
    end
    if (key == KEY_MODE) begin
      if (edit_mode) begin
        second_count = '0;
      end
      edit_mode = !edit_mode;
      mode_changes++;
    end
    show = tick_count < blink_split;
    if (edit_mode) begin
      if (key == KEY_SEL) begin
        minute_field = !minute_field;
      end
      if (key == KEY_INC) begin
        if (minute_field) begin
          minute_count = (minute_count >= MINUTE_MAX) ? 6'd0 : minute_count + 6'd1;
        end else begin
          hour_count = (hour_count >= HOUR_MAX) ? 5'd0 : hour_count + 5'd1;
        end
      end
      if (key == KEY_DEC) begin
        if (minute_field) begin
          minute_count = (minute_count == 0 || minute_count > MINUTE_MAX) ?
                         MINUTE_MAX : minute_count - 6'd1;
        end else begin
          hour_count = (hour_count == 0 || hour_count > HOUR_MAX) ?
                       HOUR_MAX : hour_count - 5'd1;
        end
      end
    end
    r.seg_hour_tens   = SEG_CODE[hour_count / 10];
    r.seg_hour_ones   = SEG_CODE[hour_count % 10];
    r.seg_minute_tens = SEG_CODE[minute_count / 10];
    r.seg_minute_ones = SEG_CODE[minute_count % 10];
    r.hour_value      = hour_count;
    r.minute_value    = minute_count;
    r.editing         = edit_mode;
    r.minute_selected = minute_field;
    if (!edit_mode) begin
      if (show) begin
        r.seg_hour_ones = r.seg_hour_ones | POINT_BIT;
      end
      if (second_count >= SECOND_WRAP) begin
        second_count = '0;
        minute_count = minute_count + 6'd1;
        if (minute_count > MINUTE_MAX) begin
          minute_count = '0;
          hour_count = hour_count + 5'd1;
          if (hour_count > HOUR_MAX) begin
            hour_count = '0;
            hour_wraps++;
          end
        end
      end
    end else if (!show) begin
      if (minute_field) begin
        r.seg_minute_tens = SEG_BLANK;
        r.seg_minute_ones = SEG_BLANK;
      end else begin
        r.seg_hour_tens = SEG_BLANK;
        r.seg_hour_ones = SEG_BLANK;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected 0x%02h, got 0x%02h", $time, name, want, got);
      end
    end
  endtask

  task automatic send_sample(input logic tick, input logic [3:0] sw,
                             input bit typed = 1'b0, input result_t want = '0);
    result_t predicted;
    int      gap;
    if (pacing && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      samples_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    samples_ch.valid    <= 1'b1;
    samples_ch.tick     <= tick;
    samples_ch.switches <= sw;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    predicted = advance_clock(tick, sw);
    pending_displays.push_back(typed ? want : predicted);
    requests_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic halt_and_drain();
    samples_ch.valid <= 1'b0;
    while (pending_displays.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SECOND_LIMIT) begin
      second_limit = value;
    end else begin
      blink_split = value;
    end
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input bit tick_always);
    int         left;
    int         hold;
    int         rest_len;
    logic [3:0] key;
    left = count;
    while (left > 0) begin
      if (allow_idle && $urandom_range(0, 39) == 0) begin
        pacing = !pacing;
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0, 1, 2: key = KEY_INC;
          3, 4, 5: key = KEY_DEC;
          6, 7:    key = KEY_SEL;
          8:       key = KEY_MODE;
          default: key = 4'($urandom_range(0, 14));
        endcase
        hold = $urandom_range(1, 3);
        rest_len = $urandom_range(1, 3);
        repeat (hold) send_sample(tick_always ? 1'b1 : 1'($urandom_range(0, 1)), key);
        repeat (rest_len) begin
          send_sample(tick_always ? 1'b1 : 1'($urandom_range(0, 1)), KEY_NONE);
        end
        left -= hold + rest_len;
      end else begin
        send_sample(tick_always ? 1'b1 : 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        left--;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst || !pacing) begin
      display_ch.ready <= 1'b1;
    end else begin
      display_ch.ready <= stall_pattern[0];
      if ($urandom_range(0, 31) == 0) begin
        stall_pattern <= 16'($urandom) | 16'h8001;
      end else begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if ((samples_ch.valid && samples_ch.ready) || (display_ch.valid && display_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[settable_clock_with_segment_display] ERROR");
        $finish;
      end
      if (display_ch.valid && display_ch.ready) begin
        got = '{display_ch.seg_hour_tens, display_ch.seg_hour_ones,
                display_ch.seg_minute_tens, display_ch.seg_minute_ones,
                display_ch.hour_value, display_ch.minute_value,
                display_ch.editing, display_ch.minute_selected};
        if (pending_displays.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: result with no request pending, expected none, got %p", $time, got);
          end
        end else begin
          want = pending_displays.pop_front();
          results_checked++;
          check_field("seg_hour_tens", want.seg_hour_tens, got.seg_hour_tens);
          check_field("seg_hour_ones", want.seg_hour_ones, got.seg_hour_ones);
          check_field("seg_minute_tens", want.seg_minute_tens, got.seg_minute_tens);
          check_field("seg_minute_ones", want.seg_minute_ones, got.seg_minute_ones);
          check_field("hour_value", 8'(want.hour_value), 8'(got.hour_value));
          check_field("minute_value", 8'(want.minute_value), 8'(got.minute_value));
          check_field("editing", 8'(want.editing), 8'(got.editing));
          check_field("minute_selected", 8'(want.minute_selected), 8'(got.minute_selected));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_SECOND_LIMIT;
    cfg_data = '0;
    samples_ch.valid = 1'b0;
    samples_ch.tick = 1'b0;
    samples_ch.switches = KEY_NONE;
    display_ch.ready = 1'b0;
    stall_pattern = 16'hFFFF;
    pacing = 1'b0;
    allow_idle = 1'b1;
    burst_left = 0;
    idle_cycles = 0;
    second_limit = SECOND_LIMIT_RESET;
    blink_split = BLINK_SPLIT_RESET;
    tick_count = '0;
    second_count = '0;
    minute_count = '0;
    hour_count = '0;
    edit_mode = 1'b0;
    minute_field = 1'b1;
    key_armed = 1'b1;

    directed_rows = '{
      '{1'b0, KEY_NONE,  1'b1, '{8'hE7, 8'hF7, 8'hE7, 8'hE7, 5'd0, 6'd0, 1'b0, 1'b1}},
      '{1'b0, KEY_MODE,  1'b1, '{8'hE7, 8'hE7, 8'hE7, 8'hE7, 5'd0, 6'd0, 1'b1, 1'b1}},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_DEC,   1'b1, '{8'hE7, 8'hE7, 8'h6E, 8'h6F, 5'd0, 6'd59, 1'b1, 1'b1}},
      '{1'b0, KEY_DEC,   1'b0, '0},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_SEL,   1'b0, '0},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_DEC,   1'b1, '{8'hCB, 8'h6B, 8'h6E, 8'h6F, 5'd23, 6'd59, 1'b1, 1'b0}},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_INC,   1'b0, '0},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_DEC,   1'b0, '0},
      '{1'b1, KEY_NONE,  1'b0, '0},
      '{1'b1, KEY_STRAY, 1'b0, '0},
      '{1'b1, KEY_INC,   1'b0, '0},
      '{1'b1, KEY_NONE,  1'b0, '0},
      '{1'b1, KEY_SEL,   1'b0, '0},
      '{1'b1, KEY_NONE,  1'b0, '0},
      '{1'b1, KEY_INC,   1'b0, '0},
      '{1'b1, KEY_NONE,  1'b0, '0},
      '{1'b1, KEY_DEC,   1'b0, '0},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_MODE,  1'b0, '0},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_INC,   1'b0, '0},
      '{1'b0, KEY_NONE,  1'b0, '0},
      '{1'b0, KEY_SEL,   1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    pacing = 1'b1;

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].tick, directed_rows[i].switches,
                  directed_rows[i].typed, directed_rows[i].want);
    end
    halt_and_drain();

    // With a zero limit every tick is a second, so the clock rolls from 23:59 to 00:00.
    write_register(CFG_SECOND_LIMIT, 16'd0);
    write_register(CFG_BLINK_SPLIT, 16'd0);
    repeat (62) send_sample(1'b1, KEY_NONE);
    run_random(150, 1'b0);
    halt_and_drain();

    write_register(CFG_SECOND_LIMIT, 16'd1);
    write_register(CFG_BLINK_SPLIT, 16'hFFFF);
    run_random(150, 1'b0);
    halt_and_drain();

    write_register(CFG_SECOND_LIMIT, 16'($urandom_range(2, 20)));
    write_register(CFG_BLINK_SPLIT, 16'($urandom_range(0, 20)));
    run_random(75, 1'b0);
    halt_and_drain();
    run_random(75, 1'b0);
    halt_and_drain();

    // Lowering the limit below the running count leaves the counter running on above it.
    pacing = 1'b0;
    allow_idle = 1'b0;
    write_register(CFG_SECOND_LIMIT, 16'd10);
    write_register(CFG_BLINK_SPLIT, 16'd5);
    repeat (8) send_sample(1'b1, KEY_NONE);
    halt_and_drain();
    write_register(CFG_SECOND_LIMIT, 16'd3);
    write_register(CFG_BLINK_SPLIT, 16'hFFFF);
    run_random(40, 1'b1);
    halt_and_drain();

    pacing = 1'b1;
    allow_idle = 1'b1;
    write_register(CFG_SECOND_LIMIT, 16'hFFFF);
    write_register(CFG_BLINK_SPLIT, 16'h8000);
    run_random(100, 1'b0);
    halt_and_drain();
    repeat (10) @(negedge clk);

    $display("Run covered %0d requests and %0d checked results, %0d mode changes,",
             requests_sent, results_checked, mode_changes);
    $display("%0d midnight rollovers, second limits 0 to 65535 and blink splits 0 to 65535.",
             hour_wraps);
    if (errors == 0 && pending_displays.size() == 0) begin
      $display("[settable_clock_with_segment_display] OK");
    end else begin
      $display("[settable_clock_with_segment_display] ERROR");
    end
    $finish;
  end

endmodule

>>> settable_clock_with_segment_display.f
+incdir+hdl
hdl/scd_pkg.sv
hdl/scd_in_if.sv
hdl/scd_out_if.sv
hdl/scd_core.sv
hdl/scd_seg.sv
hdl/settable_clock_with_segment_display.sv
dv/settable_clock_with_segment_display_tb.sv
